// File: hdl/mvrb_pkg.sv
// shared types, codes and defaults for the mesh vertex ring builder
package mvrb_pkg;

  // default sizes
  localparam int MAX_VERTICES_DEF  = 4096;
  localparam int MAX_TRIANGLES_DEF = 8192;
  localparam int MAX_DEGREE_DEF    = 16;

  // field widths
  localparam int CORNER_W = 12;
  localparam int VALUE_W  = 13;
  localparam int RING_MAX = 16;

  // opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic [2:0] ST_LOADED    = 3'd0;
  localparam logic [2:0] ST_REJECTED  = 3'd1;
  localparam logic [2:0] ST_RING      = 3'd2;
  localparam logic [2:0] ST_UNMATCHED = 3'd3;
  localparam logic [2:0] ST_UNUSED    = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  // one result item
  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] ring_value;
    logic [3:0]  ring_position;
    logic [4:0]  vertex_degree;
    logic        degree_overflow;
    logic        last_of_run;
  } res_t;

endpackage

// File: hdl/mvrb_ram.sv
// synchronous ram, one write port and one registered read port
module mvrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/mvrb_out_stage.sv
// output register that decouples result production from the receiver
module mvrb_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mvrb_pkg::res_t din,
  output logic          space,
  output logic          result_valid,
  input  logic          result_stall,
  output mvrb_pkg::res_t dout
);

  assign space = !result_valid || !result_stall;

  // hold while stalled, refill on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (space) begin
      result_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (space && push) begin
      dout <= din;
    end
  end

endmodule

// File: hdl/mesh_vertex_ring_builder_unit.sv
// Mesh vertex ring builder: loads triangles into memory and answers one-ring queries.
// Input channel (item_valid/item_stall): opcode load, query or clear with corners and
// query vertex. Output channel (result_valid/result_stall): one or more results per
// item, the final one marked by last_of_run.
// One item is processed at a time; item_stall is high while an item is in work.
// Load: three read-modify-write passes over the incidence count memory.
// Query: reads the degree, then per incident triangle reads its list entry, then its
// corners, and stores the corner pair; then for each ring slot searches the candidate
// pairs, with one pair memory read per probe.
// Clear and reset: a clearing pass writes all MAX_VERTICES count memory entries, one
// entry per cycle, during which no item is taken; clear then reports one result.
// Results go through an output register; a stalled receiver freezes the producing
// state until the pending result moves on, and nothing is dropped.
module mesh_vertex_ring_builder_unit #(
  parameter int MAX_VERTICES  = mvrb_pkg::MAX_VERTICES_DEF,
  parameter int MAX_TRIANGLES = mvrb_pkg::MAX_TRIANGLES_DEF,
  parameter int MAX_DEGREE    = mvrb_pkg::MAX_DEGREE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  opcode,
  input  logic [11:0] corner_a,
  input  logic [11:0] corner_b,
  input  logic [11:0] corner_c,
  input  logic [11:0] query_vertex,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [12:0] ring_value,
  output logic [3:0]  ring_position,
  output logic [4:0]  vertex_degree,
  output logic        degree_overflow,
  output logic        last_of_run
);

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int TW  = $clog2(MAX_TRIANGLES);
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int DW  = $clog2(MAX_DEGREE);
  localparam int LAW = $clog2(MAX_VERTICES * MAX_DEGREE);
  localparam int PW  = 2 * mvrb_pkg::CORNER_W + TW;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_EMIT    = 4'd2;
  localparam logic [3:0] S_LD_RD   = 4'd3;
  localparam logic [3:0] S_LD_WR   = 4'd4;
  localparam logic [3:0] S_Q_CNT   = 4'd5;
  localparam logic [3:0] S_G_RDL   = 4'd6;
  localparam logic [3:0] S_G_RDT   = 4'd7;
  localparam logic [3:0] S_G_PR    = 4'd8;
  localparam logic [3:0] S_R0      = 4'd9;
  localparam logic [3:0] S_R1      = 4'd10;
  localparam logic [3:0] S_K_START = 4'd11;
  localparam logic [3:0] S_SRD     = 4'd12;
  localparam logic [3:0] S_SCHK    = 4'd13;
  localparam logic [3:0] S_K_TN    = 4'd14;

  logic [3:0]          state;
  logic [VAW-1:0]      clr_addr;
  logic                clr_emit;
  logic [11:0]         lowest;
  logic [TW:0]         total;
  mvrb_pkg::res_t      pend;
  logic [2:0][11:0]    cr;
  logic [1:0]          lj;
  logic                drop;
  logic [VAW-1:0]      qv;
  logic [CW-1:0]       n;
  logic                ovf;
  logic [CW-1:0]       gk;
  logic [TW-1:0]       gt;
  logic [MAX_DEGREE-1:0] used;
  logic [11:0]         pa0;
  logic [11:0]         pb0;
  logic [3:0]          rk;
  logic                unm;
  logic [11:0]         lastv;
  logic [CW-1:0]       sj;

  logic                accept;
  logic [12:0]         qsum;
  logic                ld_bad;
  logic [VAW-1:0]      cj_addr;

  logic                cnt_we;
  logic [VAW-1:0]      cnt_waddr;
  logic [CW:0]         cnt_wdata;
  logic [VAW-1:0]      cnt_raddr;
  logic [CW:0]         cnt_rdata;
  logic [CW-1:0]       cnt_rd;
  logic                ovf_rd;
  logic                cnt_room;

  logic                lst_we;
  logic [LAW-1:0]      lst_waddr;
  logic [LAW-1:0]      lst_raddr;
  logic [TW-1:0]       lst_rdata;

  logic                tri_we;
  logic [35:0]         tri_rdata;
  logic [11:0]         tc0, tc1, tc2, gpa, gpb;

  logic                pr_we;
  logic [DW-1:0]       pr_raddr;
  logic [PW-1:0]       pr_rdata;
  logic [11:0]         pr_a, pr_b, other;
  logic [TW-1:0]       pr_t;
  logic                hit;

  logic [4:0]          lenc;
  logic                is_last;
  logic                emit;
  logic                fire;
  logic                space;
  mvrb_pkg::res_t      eres;
  mvrb_pkg::res_t      ores;

  // single result of an item, closing its run
  function automatic mvrb_pkg::res_t single_res(input logic [2:0] st, input logic [12:0] val,
                                                input logic ov);
    mvrb_pkg::res_t r;
    r                 = '0;
    r.status          = st;
    r.ring_value      = val;
    r.degree_overflow = ov;
    r.last_of_run     = 1'b1;
    return r;
  endfunction

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign qsum       = 13'(query_vertex) + 13'(lowest);
  assign ld_bad     = (32'(corner_a) >= 32'(MAX_VERTICES)) ||
                      (32'(corner_b) >= 32'(MAX_VERTICES)) ||
                      (32'(corner_c) >= 32'(MAX_VERTICES)) ||
                      (32'(total) >= 32'(MAX_TRIANGLES));
  assign cj_addr    = VAW'(cr[lj]);

  // incidence count and overflow mark memory
  assign cnt_rd   = cnt_rdata[CW-1:0];
  assign ovf_rd   = cnt_rdata[CW];
  assign cnt_room = 32'(cnt_rd) < 32'(MAX_DEGREE);

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = clr_addr;
    cnt_wdata = '0;
    if (state == S_CLR) begin
      cnt_we = 1'b1;
    end else if (state == S_LD_WR) begin
      cnt_we    = 1'b1;
      cnt_waddr = cj_addr;
      cnt_wdata = cnt_room ? {ovf_rd, CW'(cnt_rd + 1'b1)} : {1'b1, cnt_rd};
    end
  end

  assign cnt_raddr = (state == S_LD_RD) ? cj_addr : VAW'(qsum);

  mvrb_ram #(.WIDTH(CW + 1), .DEPTH(MAX_VERTICES)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  // incidence list memory, MAX_DEGREE slots per vertex
  assign lst_we    = (state == S_LD_WR) && cnt_room;
  assign lst_waddr = LAW'(cj_addr) * LAW'(MAX_DEGREE) + LAW'(cnt_rd);
  assign lst_raddr = LAW'(qv) * LAW'(MAX_DEGREE) + LAW'(gk);

  mvrb_ram #(.WIDTH(TW), .DEPTH(MAX_VERTICES * MAX_DEGREE)) u_lst (
    .clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(total[TW-1:0]),
    .raddr(lst_raddr), .rdata(lst_rdata)
  );

  // triangle corner memory
  assign tri_we = accept && (opcode == mvrb_pkg::OP_LOAD) && !ld_bad;

  mvrb_ram #(.WIDTH(36), .DEPTH(MAX_TRIANGLES)) u_tri (
    .clk(clk), .we(tri_we), .waddr(total[TW-1:0]),
    .wdata({corner_c, corner_b, corner_a}),
    .raddr(lst_rdata), .rdata(tri_rdata)
  );

  // corner pair of a gathered triangle, seen from the queried vertex
  assign tc0 = tri_rdata[11:0];
  assign tc1 = tri_rdata[23:12];
  assign tc2 = tri_rdata[35:24];

  always_comb begin
    gpa = tc1;
    gpb = tc2;
    if (32'(tc0) == 32'(qv)) begin
      gpa = tc1;
      gpb = tc2;
    end else if (32'(tc1) == 32'(qv)) begin
      gpa = tc2;
      gpb = tc0;
    end else if (32'(tc2) == 32'(qv)) begin
      gpa = tc0;
      gpb = tc1;
    end
  end

  // per-query pair memory
  assign pr_we = (state == S_G_PR);

  always_comb begin
    case (state)
      S_SRD, S_SCHK: pr_raddr = DW'(sj);
      default:       pr_raddr = DW'(rk);
    endcase
  end

  mvrb_ram #(.WIDTH(PW), .DEPTH(MAX_DEGREE)) u_pair (
    .clk(clk), .we(pr_we), .waddr(DW'(gk)), .wdata({gpa, gpb, gt}),
    .raddr(pr_raddr), .rdata(pr_rdata)
  );

  assign pr_a  = pr_rdata[PW-1 -: 12];
  assign pr_b  = pr_rdata[PW-13 -: 12];
  assign pr_t  = pr_rdata[TW-1:0];
  assign hit   = !used[DW'(sj)] && ((pr_a == lastv) || (pr_b == lastv));
  assign other = (pr_a == lastv) ? pr_b : pr_a;

  // ring length and end of run
  always_comb begin
    if (32'(n) < 2) begin
      lenc = 5'd2;
    end else if (32'(n) > mvrb_pkg::RING_MAX) begin
      lenc = 5'(mvrb_pkg::RING_MAX);
    end else begin
      lenc = 5'(n);
    end
  end

  assign is_last = ({1'b0, rk} == (lenc - 5'd1));

  // result selection
  always_comb begin
    emit                 = 1'b0;
    eres                 = pend;
    eres.status          = mvrb_pkg::ST_RING;
    eres.ring_value      = 13'(other) - 13'(lowest);
    eres.ring_position   = rk;
    eres.vertex_degree   = 5'(n);
    eres.degree_overflow = ovf;
    eres.last_of_run     = is_last;
    case (state)
      S_EMIT: begin
        emit = 1'b1;
        eres = pend;
      end
      S_R0: begin
        emit            = 1'b1;
        eres.ring_value = 13'(pa0) - 13'(lowest);
      end
      S_R1: begin
        emit            = 1'b1;
        eres.ring_value = 13'(pb0) - 13'(lowest);
      end
      S_SCHK: begin
        emit = hit;
      end
      S_K_TN: begin
        emit            = 1'b1;
        eres.status     = mvrb_pkg::ST_UNMATCHED;
        eres.ring_value = 13'(pr_t);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign fire = emit && space;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      clr_emit <= 1'b0;
      lowest   <= '1;
      total    <= '0;
    end else begin
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == VAW'(MAX_VERTICES - 1)) begin
            if (clr_emit) begin
              pend  <= single_res(mvrb_pkg::ST_CLEARED, 13'd0, 1'b0);
              state <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (opcode)
              mvrb_pkg::OP_LOAD: begin
                if (ld_bad) begin
                  pend  <= single_res(mvrb_pkg::ST_REJECTED, 13'd0, 1'b0);
                  state <= S_EMIT;
                end else begin
                  cr    <= {corner_c, corner_b, corner_a};
                  lj    <= 2'd0;
                  drop  <= 1'b0;
                  state <= S_LD_RD;
                end
              end
              mvrb_pkg::OP_QUERY: begin
                qv <= VAW'(qsum);
                if (32'(qsum) >= 32'(MAX_VERTICES)) begin
                  pend  <= single_res(mvrb_pkg::ST_UNUSED, 13'd0, 1'b0);
                  state <= S_EMIT;
                end else begin
                  state <= S_Q_CNT;
                end
              end
              mvrb_pkg::OP_CLEAR: begin
                lowest   <= '1;
                total    <= '0;
                clr_addr <= '0;
                clr_emit <= 1'b1;
                state    <= S_CLR;
              end
              default: begin
                pend  <= single_res(mvrb_pkg::ST_REJECTED, 13'd0, 1'b0);
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_EMIT: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        S_LD_RD: begin
          state <= S_LD_WR;
        end
        S_LD_WR: begin
          if (cr[lj] < lowest) begin
            lowest <= cr[lj];
          end
          if (lj == 2'd2) begin
            total <= total + 1'b1;
            pend  <= single_res(mvrb_pkg::ST_LOADED, 13'(total), drop || !cnt_room);
            state <= S_EMIT;
          end else begin
            drop  <= drop || !cnt_room;
            lj    <= lj + 2'd1;
            state <= S_LD_RD;
          end
        end
        S_Q_CNT: begin
          n   <= cnt_rd;
          ovf <= ovf_rd;
          if (cnt_rd == '0) begin
            pend  <= single_res(mvrb_pkg::ST_UNUSED, 13'd0, ovf_rd);
            state <= S_EMIT;
          end else begin
            gk    <= '0;
            used  <= '0;
            state <= S_G_RDL;
          end
        end
        S_G_RDL: begin
          state <= S_G_RDT;
        end
        S_G_RDT: begin
          gt    <= lst_rdata;
          state <= S_G_PR;
        end
        S_G_PR: begin
          if (gk == '0) begin
            pa0 <= gpa;
            pb0 <= gpb;
          end
          gk <= gk + 1'b1;
          if (CW'(gk + 1'b1) == n) begin
            rk    <= 4'd0;
            unm   <= 1'b0;
            state <= S_R0;
          end else begin
            state <= S_G_RDL;
          end
        end
        S_R0: begin
          if (fire) begin
            rk    <= 4'd1;
            state <= S_R1;
          end
        end
        S_R1: begin
          if (fire) begin
            lastv <= pb0;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              rk    <= 4'd2;
              state <= S_K_START;
            end
          end
        end
        S_K_START: begin
          if (unm) begin
            state <= S_K_TN;
          end else begin
            sj    <= CW'(1);
            state <= S_SRD;
          end
        end
        S_SRD: begin
          if (sj >= n) begin
            unm   <= 1'b1;
            state <= S_K_START;
          end else begin
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (hit) begin
            if (fire) begin
              used[DW'(sj)] <= 1'b1;
              lastv         <= other;
              if (is_last) begin
                state <= S_IDLE;
              end else begin
                rk    <= rk + 4'd1;
                state <= S_K_START;
              end
            end
          end else begin
            sj    <= sj + 1'b1;
            state <= S_SRD;
          end
        end
        S_K_TN: begin
          if (fire) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              rk    <= rk + 4'd1;
              state <= S_K_START;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  mvrb_out_stage u_out (
    .clk(clk), .rst(rst), .push(emit), .din(eres), .space(space),
    .result_valid(result_valid), .result_stall(result_stall), .dout(ores)
  );

  assign status          = ores.status;
  assign ring_value      = ores.ring_value;
  assign ring_position   = ores.ring_position;
  assign vertex_degree   = ores.vertex_degree;
  assign degree_overflow = ores.degree_overflow;
  assign last_of_run     = ores.last_of_run;

endmodule

// File: tb/tb_mesh_vertex_ring_builder_unit.sv
// self-checking testbench for the mesh vertex ring builder unit
module tb_mesh_vertex_ring_builder_unit;

  localparam int NVERT = mvrb_pkg::MAX_VERTICES_DEF;
  localparam int NTRI  = mvrb_pkg::MAX_TRIANGLES_DEF;
  localparam int NDEG  = mvrb_pkg::MAX_DEGREE_DEF;
  localparam int RANDOM_ITEMS = 440;

  // opcode outside the defined set
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] a;
    logic [11:0] b;
    logic [11:0] c;
    logic [11:0] q;
  } mesh_cmd_t;

  // directed row: command plus an optional hand-written expectation
  typedef struct packed {
    mesh_cmd_t   cmd;
    logic        fixed;
    logic [2:0]  st;
    logic [12:0] val;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [1:0]  opcode;
  logic [11:0] corner_a;
  logic [11:0] corner_b;
  logic [11:0] corner_c;
  logic [11:0] query_vertex;
  logic        result_valid;
  logic        result_stall;
  logic [2:0]  status;
  logic [12:0] ring_value;
  logic [3:0]  ring_position;
  logic [4:0]  vertex_degree;
  logic        degree_overflow;
  logic        last_of_run;

  mesh_vertex_ring_builder_unit u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .opcode(opcode), .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .query_vertex(query_vertex),
    .result_valid(result_valid), .result_stall(result_stall),
    .status(status), .ring_value(ring_value), .ring_position(ring_position),
    .vertex_degree(vertex_degree), .degree_overflow(degree_overflow),
    .last_of_run(last_of_run)
  );

  // mirror of the mesh state
  int   tri_corner [NTRI][3];
  int   inc_tri    [NVERT][NDEG];
  int   inc_count  [NVERT];
  bit   ovf_mark   [NVERT];
  int   lowest_raw;
  int   tri_count;

  mvrb_pkg::res_t ring_results_q [$];
  int   error_count;
  bit   hold_go;

  dir_row_t directed_tbl [24] = '{
    '{'{mvrb_pkg::OP_QUERY, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, mvrb_pkg::ST_UNUSED, 13'd0},
    '{'{OP_UNKNOWN, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, mvrb_pkg::ST_REJECTED, 13'd0},
    '{'{mvrb_pkg::OP_LOAD, 12'd10, 12'd11, 12'd12, 12'd0}, 1'b1, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_LOAD, 12'd10, 12'd12, 12'd13, 12'd0}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_LOAD, 12'd10, 12'd13, 12'd14, 12'd0}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_LOAD, 12'd10, 12'd14, 12'd11, 12'd0}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_QUERY, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_QUERY, 12'd0, 12'd0, 12'd0, 12'd1}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_QUERY, 12'd0, 12'd0, 12'd0, 12'd4}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_LOAD, 12'd20, 12'd20, 12'd21, 12'd0}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_QUERY, 12'd0, 12'd0, 12'd0, 12'd10}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_QUERY, 12'd0, 12'd0, 12'd0, 12'd11}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_LOAD, 12'd30, 12'd31, 12'd32, 12'd0}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_LOAD, 12'd31, 12'd40, 12'd41, 12'd0}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_LOAD, 12'd31, 12'd50, 12'd51, 12'd0}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_QUERY, 12'd0, 12'd0, 12'd0, 12'd21}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_QUERY, 12'd0, 12'd0, 12'd0, 12'd4095}, 1'b1, mvrb_pkg::ST_UNUSED,
      13'd0},
    '{'{mvrb_pkg::OP_LOAD, 12'd4095, 12'd4095, 12'd4095, 12'd0}, 1'b0, mvrb_pkg::ST_LOADED,
      13'd0},
    '{'{mvrb_pkg::OP_QUERY, 12'd0, 12'd0, 12'd0, 12'd4085}, 1'b0, mvrb_pkg::ST_LOADED,
      13'd0},
    '{'{mvrb_pkg::OP_LOAD, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_QUERY, 12'd0, 12'd0, 12'd0, 12'd4095}, 1'b0, mvrb_pkg::ST_LOADED,
      13'd0},
    '{'{mvrb_pkg::OP_QUERY, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, mvrb_pkg::ST_LOADED, 13'd0},
    '{'{mvrb_pkg::OP_CLEAR, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, mvrb_pkg::ST_CLEARED, 13'd0},
    '{'{mvrb_pkg::OP_QUERY, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, mvrb_pkg::ST_UNUSED, 13'd0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic mvrb_pkg::res_t make_res(logic [2:0] st, int val, int pos, int deg,
                                               int ovf, bit last);
    mvrb_pkg::res_t r;
    r.status          = st;
    r.ring_value      = val[12:0];
    r.ring_position   = pos[3:0];
    r.vertex_degree   = deg[4:0];
    r.degree_overflow = ovf[0];
    r.last_of_run     = last;
    return r;
  endfunction

  task automatic clear_mesh();
    for (int i = 0; i < NVERT; i++) begin
      inc_count[i] = 0;
      ovf_mark[i]  = 1'b0;
    end
    lowest_raw = NVERT - 1;
    tri_count  = 0;
  endtask

  // load: append the triangle to each corner's incidence list
  task automatic apply_load(input mesh_cmd_t cmd, output mvrb_pkg::res_t r);
    int cs[3];
    int v;
    int dropped;
    cs[0] = int'(cmd.a);
    cs[1] = int'(cmd.b);
    cs[2] = int'(cmd.c);
    dropped = 0;
    if (tri_count >= NTRI) begin
      r = make_res(mvrb_pkg::ST_REJECTED, 0, 0, 0, 0, 1'b1);
    end else begin
      for (int j = 0; j < 3; j++) begin
        v = cs[j];
        tri_corner[tri_count][j] = v;
        if (inc_count[v] < NDEG) begin
          inc_tri[v][inc_count[v]] = tri_count;
          inc_count[v]++;
        end else begin
          ovf_mark[v] = 1'b1;
          dropped = 1;
        end
        if (v < lowest_raw) lowest_raw = v;
      end
      r = make_res(mvrb_pkg::ST_LOADED, tri_count, 0, 0, dropped, 1'b1);
      tri_count++;
    end
  endtask

  // query: chain the corner pairs into an ordered neighbour loop
  task automatic queue_ring(input mesh_cmd_t cmd);
    int v, n, w, len, prev, ovf;
    int pa[NDEG];
    int pb[NDEG];
    bit used[NDEG];
    int ring[NDEG + 1];
    bit unm[NDEG + 1];
    v = int'(cmd.q) + lowest_raw;
    if (v >= NVERT) begin
      ring_results_q.push_back(make_res(mvrb_pkg::ST_UNUSED, 0, 0, 0, 0, 1'b1));
      return;
    end
    n = inc_count[v];
    ovf = int'(ovf_mark[v]);
    if (n == 0) begin
      ring_results_q.push_back(make_res(mvrb_pkg::ST_UNUSED, 0, 0, 0, ovf, 1'b1));
      return;
    end
    for (int k = 0; k < n; k++) begin
      w = 0;
      for (int j = 2; j >= 0; j--)
        if (tri_corner[inc_tri[v][k]][j] == v) w = j;
      pa[k] = tri_corner[inc_tri[v][k]][(w + 1) % 3];
      pb[k] = tri_corner[inc_tri[v][k]][(w + 2) % 3];
      used[k] = 1'b0;
    end
    len = (n < 2) ? 2 : n;
    ring[0] = pa[0];
    ring[1] = pb[0];
    unm[0] = 1'b0;
    unm[1] = 1'b0;
    for (int k = 2; k < len; k++) begin
      ring[k] = inc_tri[v][k];
      unm[k] = 1'b1;
      if (!unm[k-1]) begin
        prev = ring[k-1];
        for (int j = 1; j < n; j++) begin
          if (unm[k] && !used[j] && (pa[j] == prev || pb[j] == prev)) begin
            ring[k] = (pa[j] == prev) ? pb[j] : pa[j];
            unm[k] = 1'b0;
            used[j] = 1'b1;
          end
        end
      end
    end
    if (len > mvrb_pkg::RING_MAX) len = mvrb_pkg::RING_MAX;
    for (int k = 0; k < len; k++) begin
      if (unm[k])
        ring_results_q.push_back(make_res(mvrb_pkg::ST_UNMATCHED, ring[k], k, n, ovf,
                                          k + 1 == len));
      else
        ring_results_q.push_back(make_res(mvrb_pkg::ST_RING, ring[k] - lowest_raw, k, n, ovf,
                                          k + 1 == len));
    end
  endtask

  task automatic predict_item(input mesh_cmd_t cmd);
    mvrb_pkg::res_t r;
    case (cmd.op)
      mvrb_pkg::OP_LOAD: begin
        apply_load(cmd, r);
        ring_results_q.push_back(r);
      end
      mvrb_pkg::OP_QUERY: queue_ring(cmd);
      mvrb_pkg::OP_CLEAR: begin
        clear_mesh();
        ring_results_q.push_back(make_res(mvrb_pkg::ST_CLEARED, 0, 0, 0, 0, 1'b1));
      end
      default: ring_results_q.push_back(make_res(mvrb_pkg::ST_REJECTED, 0, 0, 0, 0, 1'b1));
    endcase
  endtask

  // sender: bursts with random gaps, waits for each transfer
  int burst_left;
  task automatic send_cmd(input mesh_cmd_t cmd, input bit fixed,
                          input mvrb_pkg::res_t fixed_res);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    opcode       <= cmd.op;
    corner_a     <= cmd.a;
    corner_b     <= cmd.b;
    corner_c     <= cmd.c;
    query_vertex <= cmd.q;
    do @(posedge clk); while (item_stall);
    if (fixed) begin
      // state still follows the mirror, the expectation comes from the table
      predict_item(cmd);
      void'(ring_results_q.pop_back());
      ring_results_q.push_back(fixed_res);
    end else begin
      predict_item(cmd);
    end
  endtask

  task automatic send_plain(input mesh_cmd_t cmd);
    send_cmd(cmd, 1'b0, '0);
  endtask

  function automatic mesh_cmd_t mk_cmd(logic [1:0] op, int a, int b, int c, int q);
    mesh_cmd_t m;
    m.op = op;
    m.a  = a[11:0];
    m.b  = b[11:0];
    m.c  = c[11:0];
    m.q  = q[11:0];
    return m;
  endfunction

  // fan around a centre, mostly well-formed, then queries into it
  task automatic fan_sequence(ref int sent);
    int centre, deg, base, rot, qn;
    int nb[20];
    int t[3];
    centre = $urandom_range(0, 4095);
    deg    = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 8);
    base   = $urandom_range(0, 4060);
    for (int i = 0; i < deg + 1; i++) nb[i] = base + i;
    if ($urandom_range(0, 3) != 0) nb[deg] = nb[0];
    if ($urandom_range(0, 4) == 0) nb[$urandom_range(0, deg)] = $urandom_range(0, 4095);
    for (int i = 0; i < deg; i++) begin
      rot = $urandom_range(0, 2);
      t[rot] = centre;
      t[(rot + 1) % 3] = nb[i];
      t[(rot + 2) % 3] = nb[i + 1];
      send_plain(mk_cmd(mvrb_pkg::OP_LOAD, t[0], t[1], t[2], 0));
      sent++;
    end
    qn = $urandom_range(1, 3);
    for (int i = 0; i < qn; i++) begin
      if (i == 0) send_plain(mk_cmd(mvrb_pkg::OP_QUERY, 0, 0, 0, centre - lowest_raw));
      else send_plain(mk_cmd(mvrb_pkg::OP_QUERY, 0, 0, 0,
                             nb[$urandom_range(0, deg)] - lowest_raw));
      sent++;
    end
  endtask

  // stimulus
  initial begin
    int sent;
    int clears;
    mvrb_pkg::res_t fr;
    item_valid   = 1'b0;
    opcode       = mvrb_pkg::OP_LOAD;
    corner_a     = '0;
    corner_b     = '0;
    corner_c     = '0;
    query_vertex = '0;
    error_count  = 0;
    burst_left   = 0;
    hold_go      = 1'b0;
    clear_mesh();
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < 24; i++) begin
      fr = make_res(directed_tbl[i].st, int'(directed_tbl[i].val), 0, 0, 0, 1'b1);
      send_cmd(directed_tbl[i].cmd, directed_tbl[i].fixed, fr);
    end

    // random: mostly fans, some noise and the odd clear
    hold_go = 1'b1;
    sent = 0;
    clears = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: fan_sequence(sent);
        12: begin
          if (clears < 3) begin
            send_plain(mk_cmd(mvrb_pkg::OP_CLEAR, 0, 0, 0, 0));
            clears++;
          end else begin
            send_plain(mk_cmd(OP_UNKNOWN, $urandom, $urandom, $urandom, $urandom));
          end
          sent++;
        end
        13, 14, 15: begin
          send_plain(mk_cmd(mvrb_pkg::OP_QUERY, 0, 0, 0,
                            ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                                        : $urandom_range(0, 40)));
          sent++;
        end
        default: begin
          send_plain(mk_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095)));
          sent++;
        end
      endcase
    end

    send_plain(mk_cmd(mvrb_pkg::OP_CLEAR, 0, 0, 0, 0));
    item_valid <= 1'b0;

    // drain
    while (ring_results_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode;
    int span;
    result_stall = 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        result_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(30, 200);
      end
      span--;
      case (mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ~result_stall;
        default: result_stall <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    mvrb_pkg::res_t want;
    if (!rst && result_valid && !result_stall) begin
      if (ring_results_q.size() == 0) begin
        report_mismatch("unexpected result, status", int'(status), -1);
      end else begin
        want = ring_results_q.pop_front();
        if (status !== want.status)
          report_mismatch("status", int'(status), int'(want.status));
        if (ring_value !== want.ring_value)
          report_mismatch("ring_value", int'(ring_value), int'(want.ring_value));
        if (ring_position !== want.ring_position)
          report_mismatch("ring_position", int'(ring_position), int'(want.ring_position));
        if (vertex_degree !== want.vertex_degree)
          report_mismatch("vertex_degree", int'(vertex_degree), int'(want.vertex_degree));
        if (degree_overflow !== want.degree_overflow)
          report_mismatch("degree_overflow", int'(degree_overflow),
                          int'(want.degree_overflow));
        if (last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", int'(last_of_run), int'(want.last_of_run));
      end
    end
  end

  // watchdog
  initial begin
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
